// ===== src/esc_pkg.sv =====
package esc_pkg;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 64;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TEMP_CALIB       = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRESS_CALIB_LO   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRESS_CALIB_HI   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRESS_CALIB_LAST = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HUM_CALIB        = 3'd4;

   // front pipeline stages ahead of the divider input register
   localparam int FRONT_STAGES = 13;
   // one quotient bit per divider stage
   localparam int DIV_STEPS    = 64;
   // pressure stages after the divider, ahead of the output register
   localparam int POST_STAGES  = 4;

   localparam logic [31:0] HUM_CLAMP = 32'd419430400;

   typedef struct packed {
      logic [19:0] raw_temp;
      logic [19:0] raw_press;
      logic [15:0] raw_hum;
   } esc_req_type;

   typedef struct packed {
      logic signed [31:0] temp_centideg;
      logic [23:0]        press_pascal;
      logic [6:0]         hum_percent;
      logic               press_divisor_zero;
   } esc_rsp_type;

   typedef struct packed {
      logic               valid;
      logic [63:0]        nq;
      logic [30:0]        rem;
      logic [30:0]        md;
      logic               neg;
      logic               zero;
      logic signed [31:0] temp;
      logic [6:0]         hum;
   } esc_div_type;

endpackage

// ===== src/esc_divider.sv =====
module esc_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  esc_pkg::esc_div_type din,
   output esc_pkg::esc_div_type dout
);
   import esc_pkg::*;

   esc_div_type st_ff [DIV_STEPS];

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
      esc_div_type prev;
      esc_div_type step_in;
      logic [31:0] trial;
      logic [31:0] diff;
      logic        take;

      if (i == 0) begin : g_first
         assign prev = din;
      end else begin : g_next
         assign prev = st_ff[i-1];
      end

      always_comb begin
         step_in = prev;
         trial = {prev.rem, prev.nq[63]};
         diff = trial - {1'b0, prev.md};
         take = trial >= {1'b0, prev.md};
         step_in.nq = {prev.nq[62:0], take};
         step_in.rem = take ? diff[30:0] : trial[30:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[i].valid <= 1'b0;
         end else if (adv) begin
            st_ff[i] <= step_in;
         end
      end
   end

   assign dout = st_ff[DIV_STEPS-1];

endmodule

// ===== src/env_sensor_compensation_unit.sv =====
// Compensates one raw temperature / pressure / humidity sample per transaction with the
// standard integer formulas, using the calibration coefficients in the csr registers.
// The block is fully pipelined: a new transaction can be accepted every cycle while the
// output is not stalled; each result passes the front stages, the 64-stage one-bit-per-stage
// pressure divider and the post stages. When the output register holds an untaken result,
// the whole pipeline stalls and req_ready drops. Write the calibration registers only
// while the pipeline is empty; a zero pressure divisor returns pressure 0 with the flag set.
module env_sensor_compensation_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  esc_pkg::esc_req_type                 req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output esc_pkg::esc_rsp_type                 rsp_data,
   input  logic                                 csr_wen,
   input  logic [esc_pkg::CSR_INDEX_WIDTH-1:0]  csr_addr,
   input  logic [esc_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import esc_pkg::*;

   logic [63:0] temp_calib_ff;
   logic [63:0] press_calib_lo_ff;
   logic [63:0] press_calib_hi_ff;
   logic [15:0] press_calib_last_ff;
   logic [63:0] hum_calib_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_calib_ff <= '0;
         press_calib_lo_ff <= '0;
         press_calib_hi_ff <= '0;
         press_calib_last_ff <= '0;
         hum_calib_ff <= '0;
      end else if (csr_wen) begin
         case (csr_addr)
            CSR_TEMP_CALIB: temp_calib_ff <= csr_wdata;
            CSR_PRESS_CALIB_LO: press_calib_lo_ff <= csr_wdata;
            CSR_PRESS_CALIB_HI: press_calib_hi_ff <= csr_wdata;
            CSR_PRESS_CALIB_LAST: press_calib_last_ff <= csr_wdata[15:0];
            CSR_HUM_CALIB: hum_calib_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // coefficients
   logic [15:0]        t1;
   logic signed [15:0] t2, t3;
   logic [15:0]        p1;
   logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
   logic signed [63:0] p4w, p7w;
   logic [7:0]         h1, h3;
   logic signed [15:0] h2;
   logic signed [31:0] h4w;
   logic signed [11:0] h5;
   logic signed [7:0]  h6;

   assign t1 = temp_calib_ff[15:0];
   assign t2 = temp_calib_ff[31:16];
   assign t3 = temp_calib_ff[47:32];
   assign p1 = press_calib_lo_ff[15:0];
   assign p2 = press_calib_lo_ff[31:16];
   assign p3 = press_calib_lo_ff[47:32];
   assign p4 = press_calib_lo_ff[63:48];
   assign p5 = press_calib_hi_ff[15:0];
   assign p6 = press_calib_hi_ff[31:16];
   assign p7 = press_calib_hi_ff[47:32];
   assign p8 = press_calib_hi_ff[63:48];
   assign p9 = press_calib_last_ff;
   assign p4w = {{48{p4[15]}}, p4};
   assign p7w = {{48{p7[15]}}, p7};
   assign h1 = hum_calib_ff[7:0];
   assign h2 = hum_calib_ff[23:8];
   assign h3 = hum_calib_ff[31:24];
   assign h4w = {{20{hum_calib_ff[43]}}, hum_calib_ff[43:32]};
   assign h5 = hum_calib_ff[55:44];
   assign h6 = hum_calib_ff[63:56];

   logic adv;
   logic rsp_valid_ff;
   esc_rsp_type rsp_data_ff;

   assign adv = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // valid bits of the front stages
   logic [FRONT_STAGES-1:0] fv_ff;
   logic [POST_STAGES-1:0]  qv_ff;
   esc_div_type div_in_ff;
   esc_div_type div_out;

   // stage 1: temperature products
   logic signed [31:0] ta_diff, td;
   logic signed [31:0] s1_ta_in, s1_dd_in, s1_ta_ff, s1_dd_ff;
   logic [19:0] s1_rp_ff;
   logic [15:0] s1_rh_ff;

   assign ta_diff = $signed({15'b0, req_data.raw_temp[19:3]}) - $signed({15'b0, t1, 1'b0});
   assign td = $signed({16'b0, req_data.raw_temp[19:4]}) - $signed({16'b0, t1});
   assign s1_ta_in = ta_diff * t2;
   assign s1_dd_in = td * td;

   // stage 2
   logic signed [31:0] s2_a_in, s2_bp_in, s2_a_ff, s2_bp_ff;
   logic [19:0] s2_rp_ff;
   logic [15:0] s2_rh_ff;
   assign s2_a_in = s1_ta_ff >>> 11;
   assign s2_bp_in = (s1_dd_ff >>> 12) * t3;

   // stage 3: fine temperature
   logic signed [31:0] s3_tf_in, s3_tf_ff;
   logic [19:0] s3_rp_ff;
   logic [15:0] s3_rh_ff;
   assign s3_tf_in = s2_a_ff + (s2_bp_ff >>> 14);

   // stage 4
   logic signed [31:0] s4_temp_in, s4_temp_ff, s4_x_in, s4_x_ff;
   logic signed [63:0] s4_v1_in, s4_v1_ff;
   logic [19:0] s4_rp_ff;
   logic [15:0] s4_rh_ff;
   assign s4_temp_in = ((s3_tf_ff <<< 2) + s3_tf_ff + 32'sd128) >>> 8;
   assign s4_v1_in = $signed({{32{s3_tf_ff[31]}}, s3_tf_ff}) - 64'sd128000;
   assign s4_x_in = s3_tf_ff - 32'sd76800;

   // stage 5
   logic [63:0] s5_sqll_in, s5_sqll_ff;
   logic [31:0] s5_sqlh_in, s5_sqlh_ff;
   logic signed [63:0] s5_v1p5_in, s5_v1p5_ff, s5_v1p2_in, s5_v1p2_ff;
   logic signed [31:0] s5_h5x_in, s5_h5x_ff, s5_xh3_in, s5_xh3_ff, s5_xh6_in, s5_xh6_ff;
   logic signed [31:0] s5_temp_ff;
   logic [19:0] s5_rp_ff;
   logic [15:0] s5_rh_ff;
   assign s5_sqll_in = s4_v1_ff[31:0] * s4_v1_ff[31:0];
   assign s5_sqlh_in = s4_v1_ff[31:0] * s4_v1_ff[63:32];
   assign s5_v1p5_in = s4_v1_ff * p5;
   assign s5_v1p2_in = s4_v1_ff * p2;
   assign s5_h5x_in = s4_x_ff * h5;
   assign s5_xh3_in = s4_x_ff * $signed({1'b0, h3});
   assign s5_xh6_in = s4_x_ff * h6;

   // stage 6
   logic signed [63:0] s6_sq_in, s6_sq_ff, s6_v1p5_ff, s6_v1p2_ff;
   logic signed [31:0] s6_lhs_in, s6_lhs_ff, s6_in1_in, s6_in1_ff, s6_xh6s_in, s6_xh6s_ff;
   logic signed [31:0] s6_temp_ff;
   logic [19:0] s6_rp_ff;
   assign s6_sq_in = $signed(s5_sqll_ff + {s5_sqlh_ff[30:0], 1'b0, 32'b0});
   assign s6_lhs_in = ($signed({2'b0, s5_rh_ff, 14'b0}) - (h4w <<< 20) - s5_h5x_ff
                       + 32'sd16384) >>> 15;
   assign s6_in1_in = (s5_xh3_ff >>> 11) + 32'sd32768;
   assign s6_xh6s_in = s5_xh6_ff >>> 10;

   // stage 7
   logic signed [63:0] s7_sqp6_in, s7_sqp6_ff, s7_sqp3_in, s7_sqp3_ff;
   logic signed [63:0] s7_v1p5_ff, s7_v1p2_ff;
   logic signed [31:0] s7_in2p_in, s7_in2p_ff, s7_lhs_ff, s7_temp_ff;
   logic [19:0] s7_rp_ff;
   assign s7_sqp6_in = s6_sq_ff * p6;
   assign s7_sqp3_in = s6_sq_ff * p3;
   assign s7_in2p_in = s6_xh6s_ff * s6_in1_ff;

   // stage 8
   logic signed [63:0] s8_v2_in, s8_v2_ff, s8_v1b_in, s8_v1b_ff;
   logic signed [31:0] s8_in2_in, s8_in2_ff, s8_lhs_ff, s8_temp_ff;
   logic [19:0] s8_rp_ff;
   assign s8_v2_in = s7_sqp6_ff + (s7_v1p5_ff <<< 17) + (p4w <<< 35);
   assign s8_v1b_in = (s7_sqp3_ff >>> 8) + (s7_v1p2_ff <<< 12);
   assign s8_in2_in = (s7_in2p_ff >>> 10) + 32'sd2097152;

   // stage 9
   logic [20:0] pdiff;
   logic signed [63:0] s9_v1cp_in, s9_v1cp_ff, s9_num0_in, s9_num0_ff;
   logic signed [31:0] s9_in2h2_in, s9_in2h2_ff, s9_lhs_ff, s9_temp_ff;
   assign pdiff = 21'd1048576 - {1'b0, s8_rp_ff};
   assign s9_v1cp_in = (s8_v1b_ff + 64'sd140737488355328) * $signed({1'b0, p1});
   assign s9_num0_in = $signed({12'b0, pdiff, 31'b0}) - s8_v2_ff;
   assign s9_in2h2_in = s8_in2_ff * h2;

   // stage 10
   logic signed [63:0] s10_den_in, s10_den_ff, s10_num_in, s10_num_ff;
   logic signed [31:0] s10_rhs_in, s10_rhs_ff, s10_lhs_ff, s10_temp_ff;
   assign s10_den_in = s9_v1cp_ff >>> 33;
   assign s10_num_in = s9_num0_ff * 64'sd3125;
   assign s10_rhs_in = (s9_in2h2_ff + 32'sd8192) >>> 14;

   // stage 11: humidity product and divider operands
   logic signed [31:0] s11_h_in, s11_h_ff, s11_temp_ff;
   logic [63:0] s11_ma_in, s11_ma_ff, den_abs;
   logic [30:0] s11_md_in, s11_md_ff;
   logic s11_neg_in, s11_neg_ff, s11_zero_in, s11_zero_ff;
   assign s11_h_in = s10_lhs_ff * s10_rhs_ff;
   assign s11_ma_in = s10_num_ff[63] ? 64'(-s10_num_ff) : s10_num_ff;
   assign den_abs = s10_den_ff[63] ? 64'(-s10_den_ff) : s10_den_ff;
   assign s11_md_in = den_abs[30:0];
   assign s11_neg_in = s10_num_ff[63] ^ s10_den_ff[63];
   assign s11_zero_in = s10_den_ff == 64'sd0;

   // stage 12
   logic signed [31:0] s12_hs, s12_hss_in, s12_hss_ff, s12_h_ff, s12_temp_ff;
   logic [63:0] s12_ma_ff;
   logic [30:0] s12_md_ff;
   logic s12_neg_ff, s12_zero_ff;
   assign s12_hs = s11_h_ff >>> 15;
   assign s12_hss_in = s12_hs * s12_hs;

   // stage 13
   logic signed [31:0] s13_hh1_in, s13_hh1_ff, s13_h_ff, s13_temp_ff;
   logic [63:0] s13_ma_ff;
   logic [30:0] s13_md_ff;
   logic s13_neg_ff, s13_zero_ff;
   assign s13_hh1_in = (s12_hss_ff >>> 7) * $signed({1'b0, h1});

   // stage 14: humidity clamp, divider input
   logic signed [31:0] hfin;
   logic [31:0] hclamp;
   esc_div_type div_in_in;
   assign hfin = s13_h_ff - (s13_hh1_ff >>> 4);
   assign hclamp = hfin[31] ? 32'd0 : ((hfin > $signed(HUM_CLAMP)) ? HUM_CLAMP : hfin);

   always_comb begin
      div_in_in.valid = fv_ff[FRONT_STAGES-1];
      div_in_in.nq = s13_ma_ff;
      div_in_in.rem = '0;
      div_in_in.md = s13_md_ff;
      div_in_in.neg = s13_neg_ff;
      div_in_in.zero = s13_zero_ff;
      div_in_in.temp = s13_temp_ff;
      div_in_in.hum = hclamp[28:22];
   end

   esc_divider u_divider (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .din   (div_in_ff),
      .dout  (div_out)
   );

   // post stage 1: signed quotient
   logic signed [63:0] q1_p_in, q1_p_ff, q1_ps_in, q1_ps_ff;
   logic signed [63:0] q1_p9ps_in, q1_p9ps_ff, q1_p8p_in, q1_p8p_ff;
   logic signed [31:0] q1_temp_ff;
   logic [6:0] q1_hum_ff;
   logic q1_zero_ff;
   assign q1_p_in = div_out.neg ? $signed(64'(-div_out.nq)) : $signed(div_out.nq);
   assign q1_ps_in = q1_p_in >>> 13;
   assign q1_p9ps_in = p9 * q1_ps_in;
   assign q1_p8p_in = p8 * q1_p_in;

   // post stage 2: partial products
   logic [63:0] q2_ll_in, q2_ll_ff;
   logic [31:0] q2_lh_in, q2_lh_ff, q2_hl_in, q2_hl_ff;
   logic signed [63:0] q2_p_ff, q2_p8p_ff;
   logic signed [31:0] q2_temp_ff;
   logic [6:0] q2_hum_ff;
   logic q2_zero_ff;
   assign q2_ll_in = q1_p9ps_ff[31:0] * q1_ps_ff[31:0];
   assign q2_lh_in = q1_p9ps_ff[31:0] * q1_ps_ff[63:32];
   assign q2_hl_in = q1_p9ps_ff[63:32] * q1_ps_ff[31:0];

   // post stage 3
   logic [31:0] cross_sum;
   logic signed [63:0] q3_v1_in, q3_v1_ff, q3_v2_in, q3_v2_ff, q3_p_ff;
   logic signed [31:0] q3_temp_ff;
   logic [6:0] q3_hum_ff;
   logic q3_zero_ff;
   assign cross_sum = q2_lh_ff + q2_hl_ff;
   assign q3_v1_in = $signed(q2_ll_ff + {cross_sum, 32'b0}) >>> 25;
   assign q3_v2_in = q2_p8p_ff >>> 19;

   // post stage 4
   logic signed [63:0] q4_sum_in, q4_sum_ff;
   logic signed [31:0] q4_temp_ff;
   logic [6:0] q4_hum_ff;
   logic q4_zero_ff;
   assign q4_sum_in = q3_p_ff + q3_v1_ff + q3_v2_ff;

   // output register
   logic signed [63:0] pfin;
   esc_rsp_type rsp_data_in;
   assign pfin = (q4_sum_ff >>> 8) + (p7w <<< 4);

   always_comb begin
      rsp_data_in.temp_centideg = q4_temp_ff;
      rsp_data_in.press_pascal = q4_zero_ff ? 24'd0 : pfin[31:8];
      rsp_data_in.hum_percent = q4_hum_ff;
      rsp_data_in.press_divisor_zero = q4_zero_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
         div_in_ff.valid <= 1'b0;
         qv_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         fv_ff <= {fv_ff[FRONT_STAGES-2:0], req_valid};
         div_in_ff <= div_in_in;
         qv_ff <= {qv_ff[POST_STAGES-2:0], div_out.valid};
         rsp_valid_ff <= qv_ff[POST_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ta_ff <= s1_ta_in;
         s1_dd_ff <= s1_dd_in;
         s1_rp_ff <= req_data.raw_press;
         s1_rh_ff <= req_data.raw_hum;

         s2_a_ff <= s2_a_in;
         s2_bp_ff <= s2_bp_in;
         s2_rp_ff <= s1_rp_ff;
         s2_rh_ff <= s1_rh_ff;

         s3_tf_ff <= s3_tf_in;
         s3_rp_ff <= s2_rp_ff;
         s3_rh_ff <= s2_rh_ff;

         s4_temp_ff <= s4_temp_in;
         s4_x_ff <= s4_x_in;
         s4_v1_ff <= s4_v1_in;
         s4_rp_ff <= s3_rp_ff;
         s4_rh_ff <= s3_rh_ff;

         s5_sqll_ff <= s5_sqll_in;
         s5_sqlh_ff <= s5_sqlh_in;
         s5_v1p5_ff <= s5_v1p5_in;
         s5_v1p2_ff <= s5_v1p2_in;
         s5_h5x_ff <= s5_h5x_in;
         s5_xh3_ff <= s5_xh3_in;
         s5_xh6_ff <= s5_xh6_in;
         s5_temp_ff <= s4_temp_ff;
         s5_rp_ff <= s4_rp_ff;
         s5_rh_ff <= s4_rh_ff;

         s6_sq_ff <= s6_sq_in;
         s6_v1p5_ff <= s5_v1p5_ff;
         s6_v1p2_ff <= s5_v1p2_ff;
         s6_lhs_ff <= s6_lhs_in;
         s6_in1_ff <= s6_in1_in;
         s6_xh6s_ff <= s6_xh6s_in;
         s6_temp_ff <= s5_temp_ff;
         s6_rp_ff <= s5_rp_ff;

         s7_sqp6_ff <= s7_sqp6_in;
         s7_sqp3_ff <= s7_sqp3_in;
         s7_v1p5_ff <= s6_v1p5_ff;
         s7_v1p2_ff <= s6_v1p2_ff;
         s7_in2p_ff <= s7_in2p_in;
         s7_lhs_ff <= s6_lhs_ff;
         s7_temp_ff <= s6_temp_ff;
         s7_rp_ff <= s6_rp_ff;

         s8_v2_ff <= s8_v2_in;
         s8_v1b_ff <= s8_v1b_in;
         s8_in2_ff <= s8_in2_in;
         s8_lhs_ff <= s7_lhs_ff;
         s8_temp_ff <= s7_temp_ff;
         s8_rp_ff <= s7_rp_ff;

         s9_v1cp_ff <= s9_v1cp_in;
         s9_num0_ff <= s9_num0_in;
         s9_in2h2_ff <= s9_in2h2_in;
         s9_lhs_ff <= s8_lhs_ff;
         s9_temp_ff <= s8_temp_ff;

         s10_den_ff <= s10_den_in;
         s10_num_ff <= s10_num_in;
         s10_rhs_ff <= s10_rhs_in;
         s10_lhs_ff <= s9_lhs_ff;
         s10_temp_ff <= s9_temp_ff;

         s11_h_ff <= s11_h_in;
         s11_temp_ff <= s10_temp_ff;
         s11_ma_ff <= s11_ma_in;
         s11_md_ff <= s11_md_in;
         s11_neg_ff <= s11_neg_in;
         s11_zero_ff <= s11_zero_in;

         s12_hss_ff <= s12_hss_in;
         s12_h_ff <= s11_h_ff;
         s12_temp_ff <= s11_temp_ff;
         s12_ma_ff <= s11_ma_ff;
         s12_md_ff <= s11_md_ff;
         s12_neg_ff <= s11_neg_ff;
         s12_zero_ff <= s11_zero_ff;

         s13_hh1_ff <= s13_hh1_in;
         s13_h_ff <= s12_h_ff;
         s13_temp_ff <= s12_temp_ff;
         s13_ma_ff <= s12_ma_ff;
         s13_md_ff <= s12_md_ff;
         s13_neg_ff <= s12_neg_ff;
         s13_zero_ff <= s12_zero_ff;

         q1_p_ff <= q1_p_in;
         q1_ps_ff <= q1_ps_in;
         q1_p9ps_ff <= q1_p9ps_in;
         q1_p8p_ff <= q1_p8p_in;
         q1_temp_ff <= div_out.temp;
         q1_hum_ff <= div_out.hum;
         q1_zero_ff <= div_out.zero;

         q2_ll_ff <= q2_ll_in;
         q2_lh_ff <= q2_lh_in;
         q2_hl_ff <= q2_hl_in;
         q2_p_ff <= q1_p_ff;
         q2_p8p_ff <= q1_p8p_ff;
         q2_temp_ff <= q1_temp_ff;
         q2_hum_ff <= q1_hum_ff;
         q2_zero_ff <= q1_zero_ff;

         q3_v1_ff <= q3_v1_in;
         q3_v2_ff <= q3_v2_in;
         q3_p_ff <= q2_p_ff;
         q3_temp_ff <= q2_temp_ff;
         q3_hum_ff <= q2_hum_ff;
         q3_zero_ff <= q2_zero_ff;

         q4_sum_ff <= q4_sum_in;
         q4_temp_ff <= q3_temp_ff;
         q4_hum_ff <= q3_hum_ff;
         q4_zero_ff <= q3_zero_ff;

         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

`ifndef SYNTH
   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.hum_percent <= 7'd100)
      else $error("humidity above clamp");

   a_zero_press: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.press_divisor_zero |-> rsp_data.press_pascal == 24'd0)
      else $error("pressure not forced to zero");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(div_out.valid) && $stable(div_in_ff.valid))
      else $error("pipeline moved during stall");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !div_in_ff.valid)
      else $error("pipeline not empty after reset");
`endif

endmodule

// ===== verif/env_sensor_compensation_unit_test.sv =====
`timescale 1ns / 100ps

module env_sensor_compensation_unit_test;
   import esc_pkg::*;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   esc_req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   esc_rsp_type rsp_data;
   logic csr_wen;
   logic [CSR_INDEX_WIDTH-1:0] csr_addr;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata;

   logic [63:0] temp_cal;
   logic [63:0] press_cal_lo;
   logic [63:0] press_cal_hi;
   logic [15:0] press_cal_last;
   logic [63:0] hum_cal;

   esc_rsp_type expected_samples[$];
   int mismatch_count;
   int sample_count;
   int result_count;
   int zero_divisor_count;
   int gap_left;

   env_sensor_compensation_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_wen(csr_wen),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("Mismatches found");
      $finish;
   end

   function automatic esc_rsp_type compensate_sample(esc_req_type s);
      logic signed [31:0] t1, t2, t3, a, d, b, tfine, temp;
      logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic signed [63:0] v1, v2, p, ps, num, mn, md, q;
      logic signed [31:0] h1, h2, h3, h4, h5, h6, x, lhs, in1, in2, rhs, h, hs;
      logic [31:0] p32;
      esc_rsp_type r;
      t1 = {16'd0, temp_cal[15:0]};
      t2 = {{16{temp_cal[31]}}, temp_cal[31:16]};
      t3 = {{16{temp_cal[47]}}, temp_cal[47:32]};
      a = (({12'd0, s.raw_temp} >>> 3) - (t1 <<< 1)) * t2;
      a = a >>> 11;
      d = ({12'd0, s.raw_temp} >>> 4) - t1;
      b = d * d;
      b = b >>> 12;
      b = b * t3;
      b = b >>> 14;
      tfine = a + b;
      temp = tfine * 5 + 128;
      r.temp_centideg = temp >>> 8;

      p1 = {48'd0, press_cal_lo[15:0]};
      p2 = {{48{press_cal_lo[31]}}, press_cal_lo[31:16]};
      p3 = {{48{press_cal_lo[47]}}, press_cal_lo[47:32]};
      p4 = {{48{press_cal_lo[63]}}, press_cal_lo[63:48]};
      p5 = {{48{press_cal_hi[15]}}, press_cal_hi[15:0]};
      p6 = {{48{press_cal_hi[31]}}, press_cal_hi[31:16]};
      p7 = {{48{press_cal_hi[47]}}, press_cal_hi[47:32]};
      p8 = {{48{press_cal_hi[63]}}, press_cal_hi[63:48]};
      p9 = {{48{press_cal_last[15]}}, press_cal_last};
      v1 = 64'(tfine) - 64'sd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) <<< 17);
      v2 = v2 + (p4 <<< 35);
      q = v1 * v1 * p3;
      v1 = (q >>> 8) + ((v1 * p2) <<< 12);
      v1 = ((64'sd1 <<< 47) + v1) * p1;
      v1 = v1 >>> 33;
      r.press_pascal = '0;
      r.press_divisor_zero = 1'b0;
      if (v1 == 0) begin
         r.press_divisor_zero = 1'b1;
      end else begin
         p = 64'sd1048576 - {44'd0, s.raw_press};
         num = ((p <<< 31) - v2) * 64'sd3125;
         mn = num[63] ? -num : num;
         md = v1[63] ? -v1 : v1;
         q = $signed(64'($unsigned(mn) / $unsigned(md)));
         p = (num[63] != v1[63]) ? -q : q;
         ps = p >>> 13;
         v1 = p9 * ps * ps;
         v1 = v1 >>> 25;
         v2 = p8 * p;
         v2 = v2 >>> 19;
         p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
         p32 = p[31:0];
         r.press_pascal = p32[31:8];
      end

      h1 = {24'd0, hum_cal[7:0]};
      h2 = {{16{hum_cal[23]}}, hum_cal[23:8]};
      h3 = {24'd0, hum_cal[31:24]};
      h4 = {{20{hum_cal[43]}}, hum_cal[43:32]};
      h5 = {{20{hum_cal[55]}}, hum_cal[55:44]};
      h6 = {{24{hum_cal[63]}}, hum_cal[63:56]};
      x = tfine - 32'sd76800;
      lhs = ({16'd0, s.raw_hum} <<< 14) - (h4 <<< 20) - (h5 * x) + 32'sd16384;
      lhs = lhs >>> 15;
      in1 = x * h3;
      in1 = (in1 >>> 11) + 32'sd32768;
      in2 = x * h6;
      in2 = in2 >>> 10;
      in2 = in2 * in1;
      in2 = (in2 >>> 10) + 32'sd2097152;
      rhs = in2 * h2 + 32'sd8192;
      rhs = rhs >>> 14;
      h = lhs * rhs;
      hs = h >>> 15;
      q = 0;
      hs = hs * hs;
      hs = hs >>> 7;
      hs = hs * h1;
      h = h - (hs >>> 4);
      if (h < 0) h = 0;
      if ($unsigned(h) > HUM_CLAMP) h = HUM_CLAMP;
      r.hum_percent = 7'($unsigned(h) >> 22);
      return r;
   endfunction

   always @(posedge clock) begin
      esc_rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_samples.size() == 0) begin
            $error("unexpected transaction %p", rsp_data);
            mismatch_count++;
         end else begin
            e = expected_samples.pop_front();
            result_count++;
            if (rsp_data.temp_centideg !== e.temp_centideg) begin
               $error("temp_centideg exp %0d got %0d", e.temp_centideg, rsp_data.temp_centideg);
               mismatch_count++;
            end
            if (rsp_data.press_pascal !== e.press_pascal) begin
               $error("press_pascal exp %0d got %0d", e.press_pascal, rsp_data.press_pascal);
               mismatch_count++;
            end
            if (rsp_data.hum_percent !== e.hum_percent) begin
               $error("hum_percent exp %0d got %0d", e.hum_percent, rsp_data.hum_percent);
               mismatch_count++;
            end
            if (rsp_data.press_divisor_zero !== e.press_divisor_zero) begin
               $error("press_divisor_zero exp %0b got %0b", e.press_divisor_zero,
                      rsp_data.press_divisor_zero);
               mismatch_count++;
            end
         end
      end
   end

   // receiver stall pattern: modes switch every so often
   initial begin
      int mode;
      int hold;
      rsp_ready = 1'b0;
      mode = 0;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold == 0) begin
            mode = $urandom_range(0, 3);
            hold = $urandom_range(10, 200);
         end
         hold--;
         case (mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= ($urandom_range(0, 19) != 0);
         endcase
      end
   end

   task automatic send_sample(input esc_req_type s);
      esc_rsp_type e;
      if (gap_left == 0 && $urandom_range(0, 7) == 0) begin
         gap_left = $urandom_range(1, 12);
      end
      if (gap_left > 0) begin
         req_valid <= 1'b0;
         while (gap_left > 0) begin
            @(negedge clock);
            gap_left--;
         end
      end
      req_valid <= 1'b1;
      req_data <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      e = compensate_sample(s);
      expected_samples.push_back(e);
      if (e.press_divisor_zero) zero_divisor_count++;
      sample_count++;
      @(negedge clock);
   endtask

   task automatic drain_pipeline;
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [63:0] value);
      csr_wen <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      case (idx)
         CSR_TEMP_CALIB: temp_cal = value;
         CSR_PRESS_CALIB_LO: press_cal_lo = value;
         CSR_PRESS_CALIB_HI: press_cal_hi = value;
         CSR_PRESS_CALIB_LAST: press_cal_last = value[15:0];
         CSR_HUM_CALIB: hum_cal = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   function automatic esc_req_type random_sample();
      esc_req_type s;
      s.raw_temp = 20'($urandom);
      s.raw_press = 20'($urandom);
      s.raw_hum = 16'($urandom);
      return s;
   endfunction

   task automatic load_typical_calibration;
      write_csr(CSR_TEMP_CALIB, {16'hFFFF, 16'h0032, 16'h6A70, 16'h6E5E});
      write_csr(CSR_PRESS_CALIB_LO, {16'h0B8F, 16'h0BD0, 16'hD6A6, 16'h8E9B});
      write_csr(CSR_PRESS_CALIB_HI, {16'hC6F8, 16'h2CC2, 16'hFFF9, 16'h008C});
      write_csr(CSR_PRESS_CALIB_LAST, 64'h0000_0000_0000_1770);
      write_csr(CSR_HUM_CALIB, {8'h1E, 12'h032, 12'h143, 8'h00, 16'h016B, 8'h4B});
   endtask

   task automatic test_reset_calibration;
      esc_req_type s;
      s = '0;
      send_sample(s);
      s = '1;
      send_sample(s);
      drain_pipeline();
   endtask

   task automatic test_directed_extremes;
      esc_req_type s;
      load_typical_calibration();
      s = '{raw_temp: 20'h7E000, raw_press: 20'h5A000, raw_hum: 16'h6E00};
      send_sample(s);
      s = '0;
      send_sample(s);
      s = '1;
      send_sample(s);
      s = '{raw_temp: 20'h80000, raw_press: 20'h00001, raw_hum: 16'h8000};
      send_sample(s);
      s = '{raw_temp: 20'h7FFFF, raw_press: 20'hFFFFF, raw_hum: 16'h7FFF};
      send_sample(s);
      s = '{raw_temp: 20'h7E000, raw_press: 20'h5A000, raw_hum: 16'hFFFF};
      send_sample(s);
      s = '{raw_temp: 20'h7E000, raw_press: 20'h5A000, raw_hum: 16'h0000};
      send_sample(s);
      drain_pipeline();
      // p1 of zero forces the zero divisor flag
      write_csr(CSR_PRESS_CALIB_LO, {16'h0B8F, 16'h0BD0, 16'hD6A6, 16'h0000});
      s = '{raw_temp: 20'h7E000, raw_press: 20'h5A000, raw_hum: 16'h6E00};
      send_sample(s);
      s = '1;
      send_sample(s);
      drain_pipeline();
      write_csr(CSR_TEMP_CALIB, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(CSR_PRESS_CALIB_LO, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(CSR_PRESS_CALIB_HI, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(CSR_PRESS_CALIB_LAST, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(CSR_HUM_CALIB, 64'hFFFF_FFFF_FFFF_FFFF);
      send_sample('0);
      send_sample('1);
      send_sample(random_sample());
      drain_pipeline();
      write_csr(CSR_TEMP_CALIB, 64'h0000_8000_8000_FFFF);
      write_csr(CSR_PRESS_CALIB_LO, 64'h8000_8000_8000_FFFF);
      write_csr(CSR_PRESS_CALIB_HI, 64'h7FFF_7FFF_8000_8000);
      write_csr(CSR_PRESS_CALIB_LAST, 64'h0000_0000_0000_8000);
      write_csr(CSR_HUM_CALIB, 64'h8080_07FF_FF7F_FFFF);
      send_sample('0);
      send_sample('1);
      send_sample(random_sample());
      drain_pipeline();
   endtask

   task automatic test_random_calibration(input int rounds);
      for (int r = 0; r < rounds; r++) begin
         write_csr(CSR_TEMP_CALIB, {$urandom, $urandom});
         write_csr(CSR_PRESS_CALIB_LO, {$urandom, $urandom});
         write_csr(CSR_PRESS_CALIB_HI, {$urandom, $urandom});
         write_csr(CSR_PRESS_CALIB_LAST, {$urandom, $urandom});
         write_csr(CSR_HUM_CALIB, {$urandom, $urandom});
         repeat (25) send_sample(random_sample());
         drain_pipeline();
      end
   endtask

   task automatic test_typical_samples(input int count);
      esc_req_type s;
      load_typical_calibration();
      for (int i = 0; i < count; i++) begin
         s.raw_temp = 20'($urandom_range(20'h60000, 20'h90000));
         s.raw_press = 20'($urandom_range(20'h40000, 20'h70000));
         s.raw_hum = 16'($urandom_range(16'h3000, 16'hA000));
         if ($urandom_range(0, 9) == 0) s = random_sample();
         send_sample(s);
      end
      drain_pipeline();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wen = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      temp_cal = '0;
      press_cal_lo = '0;
      press_cal_hi = '0;
      press_cal_last = '0;
      hum_cal = '0;
      mismatch_count = 0;
      sample_count = 0;
      result_count = 0;
      zero_divisor_count = 0;
      gap_left = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_calibration();
      test_directed_extremes();
      test_typical_samples(350);
      test_random_calibration(16);

      $display("covered %0d samples (%0d with a zero pressure divisor), %0d results checked",
               sample_count, zero_divisor_count, result_count);
      $display("under reset, extreme, typical and random calibration with gaps and stalls");
      if (expected_samples.size() != 0) begin
         $error("%0d expected transactions never arrived", expected_samples.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/esc_pkg.sv
src/esc_divider.sv
src/env_sensor_compensation_unit.sv
verif/env_sensor_compensation_unit_test.sv
